@@ src/twwc_pkg.sv @@
// twwc_pkg: shared types, register codes and reset values for the
// triggered waveform window capture block. No dependencies.

package twwc_pkg;

	// default number of capture windows that may be open at once
	localparam int unsigned CAPTURE_SLOTS_DEF = 4;

	// largest window in samples; longer settings are clamped to this
	localparam int unsigned MAX_WINDOW = 128;

	// configuration register reset values
	localparam logic signed [15:0] THRESHOLD_RST = 16'sd0;
	localparam logic [7:0]  SHIFT_RST    = 8'd25;
	localparam logic [7:0]  LENGTH_RST   = 8'd98;
	localparam logic [7:0]  HOLDOFF_RST  = 8'd30;
	localparam logic [15:0] MAXWAVES_RST = 16'd1600;
	localparam logic [15:0] LINELEN_RST  = 16'd4096;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TRIGGER_THRESHOLD  = 3'd0,
		REG_WINDOW_SHIFT       = 3'd1,
		REG_WINDOW_LENGTH      = 3'd2,
		REG_HOLDOFF_LENGTH     = 3'd3,
		REG_MAX_WAVES_PER_LINE = 3'd4,
		REG_LINE_LENGTH        = 3'd5
	} cfg_reg_e;

	// one input transaction
	typedef struct packed {
		logic signed [15:0] trigger_sample;
		logic signed [15:0] laser_sample;
	} in_item_t;

	// one result transaction
	typedef struct packed {
		logic [15:0]        line_number;
		logic [15:0]        wave_number;
		logic [6:0]         sample_offset;
		logic signed [11:0] scaled_value;
		logic               last_of_item;
	} out_item_t;

	// fields shared by every result of one input
	typedef struct packed {
		logic [15:0]        line_number;
		logic signed [11:0] scaled_value;
	} batch_hdr_t;

endpackage

@@ src/twwc_drain.sv @@
// twwc_drain: holds the results of one input and hands them out one per
// unstalled cycle via a result register, oldest first. Uses twwc_pkg.

module twwc_drain #(
	parameter int unsigned CAPTURE_SLOTS = twwc_pkg::CAPTURE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [CAPTURE_SLOTS-1:0]      mask,
	input  logic [CAPTURE_SLOTS-1:0][15:0] wave,
	input  logic [CAPTURE_SLOTS-1:0][6:0] offset,
	input  twwc_pkg::batch_hdr_t          hdr,
	output logic                          ready,
	output logic                          result_valid,
	input  logic                          result_stall,
	output twwc_pkg::out_item_t           result
);

	localparam int unsigned IDXW = (CAPTURE_SLOTS > 1) ? $clog2(CAPTURE_SLOTS) : 1;

	logic [CAPTURE_SLOTS-1:0]       mask_s2;
	logic [CAPTURE_SLOTS-1:0][15:0] wave_s2;
	logic [CAPTURE_SLOTS-1:0][6:0]  offset_s2;
	twwc_pkg::batch_hdr_t           hdr_s2;

	logic                     valid_s3;
	twwc_pkg::out_item_t      result_s3;

	logic [IDXW-1:0]          sel;
	logic [CAPTURE_SLOTS-1:0] rest;
	logic                     out_load;

	// pick the oldest pending result
	always_comb begin
		sel = '0;
		for (int i = CAPTURE_SLOTS - 1; i >= 0; i--) begin
			if (mask_s2[i]) begin
				sel = IDXW'(i);
			end
		end
		rest = mask_s2 & ~(CAPTURE_SLOTS'(1) << sel);
	end

	assign out_load = (mask_s2 != '0) && (!valid_s3 || !result_stall);
	assign ready    = (mask_s2 == '0) || (out_load && rest == '0);

	// result batch of one input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (load) begin
			mask_s2 <= mask;
		end else if (out_load) begin
			mask_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wave_s2   <= wave;
			offset_s2 <= offset;
			hdr_s2    <= hdr;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_load) begin
			valid_s3 <= 1'b1;
		end else if (!result_stall) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_s3.line_number   <= hdr_s2.line_number;
			result_s3.wave_number   <= wave_s2[sel];
			result_s3.sample_offset <= offset_s2[sel];
			result_s3.scaled_value  <= hdr_s2.scaled_value;
			result_s3.last_of_item  <= (rest == '0);
		end
	end

	assign result_valid = valid_s3;
	assign result       = result_s3;

endmodule

@@ src/triggered_waveform_window_capture.sv @@
// triggered_waveform_window_capture: top level with configuration registers,
// input register, line and trigger state, and the capture window list.
// Uses twwc_pkg and twwc_drain.

// Each accepted sample pair passes an input register, is evaluated
// against the line state and the open capture windows, and leaves
// its results (one per window whose span covers it, up to CAPTURE_SLOTS)
// in a batch that the result register hands out one per unstalled cycle,
// oldest window first, with last_of_item set on the final one. Samples
// that cause no result are taken in every cycle while no batch is pending;
// a sample with results stalls the input until the last of them enters
// the result register, so results leave it at a sustained one per
// unstalled cycle. A sample's results pass the batch register in
// twwc_drain and then the result register.
// The open windows are kept in age order, oldest at index 0, so emission
// order and freeing need no sort. cfg_ready is always high; registers are
// to be written only while the block is idle.

module triggered_waveform_window_capture #(
	parameter int unsigned CAPTURE_SLOTS = twwc_pkg::CAPTURE_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  twwc_pkg::in_item_t   sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output twwc_pkg::out_item_t  result
);

	localparam int unsigned CW = $clog2(CAPTURE_SLOTS + 1);

	// configuration registers
	logic signed [15:0] threshold_q;
	logic [7:0]         shift_q;
	logic [7:0]         length_q;
	logic [7:0]         holdoff_len_q;
	logic [15:0]        max_waves_q;
	logic [15:0]        line_len_q;

	// line state
	logic [15:0] pos_q;
	logic [15:0] line_q;
	logic [7:0]  holdoff_q;
	logic [15:0] waves_q;

	// open windows, oldest first
	logic [CAPTURE_SLOTS-1:0][8:0]  age_q;
	logic [CAPTURE_SLOTS-1:0][15:0] slot_wave_q;
	logic [CW-1:0]                  cnt_q;

	// input register
	logic               valid_s1;
	twwc_pkg::in_item_t sample_s1;

	logic batch_ready;
	logic proc;

	logic [7:0]  eff_len;
	logic [8:0]  win_end;
	logic [16:0] fit_sum;
	logic        take;
	logic [15:0] pos_inc;
	logic        wrap;
	logic [16:0] laser_adj;
	logic [CW:0] cnt_new;

	logic [CAPTURE_SLOTS-1:0][8:0]  ea;
	logic [CAPTURE_SLOTS-1:0][15:0] ew;
	logic [CAPTURE_SLOTS-1:0][6:0]  eoff;
	logic [CAPTURE_SLOTS-1:0]       live;
	logic [CAPTURE_SLOTS-1:0]       emit;
	logic [CAPTURE_SLOTS-1:0]       gone;
	logic [CW-1:0]                  nfree;
	logic [CAPTURE_SLOTS-1:0][8:0]  age_nxt;
	logic [CAPTURE_SLOTS-1:0][15:0] wave_nxt;

	twwc_pkg::batch_hdr_t hdr;

	assign cfg_ready = 1'b1;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= twwc_pkg::THRESHOLD_RST;
			shift_q       <= twwc_pkg::SHIFT_RST;
			length_q      <= twwc_pkg::LENGTH_RST;
			holdoff_len_q <= twwc_pkg::HOLDOFF_RST;
			max_waves_q   <= twwc_pkg::MAXWAVES_RST;
			line_len_q    <= twwc_pkg::LINELEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				twwc_pkg::REG_TRIGGER_THRESHOLD:  threshold_q   <= cfg_data;
				twwc_pkg::REG_WINDOW_SHIFT:       shift_q       <= cfg_data[7:0];
				twwc_pkg::REG_WINDOW_LENGTH:      length_q      <= cfg_data[7:0];
				twwc_pkg::REG_HOLDOFF_LENGTH:     holdoff_len_q <= cfg_data[7:0];
				twwc_pkg::REG_MAX_WAVES_PER_LINE: max_waves_q   <= cfg_data;
				twwc_pkg::REG_LINE_LENGTH:        line_len_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register handshake
	assign proc         = valid_s1 && batch_ready;
	assign sample_stall = valid_s1 && !batch_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	// window span, trigger decision and position step
	always_comb begin
		if (length_q == '0) begin
			eff_len = 8'd1;
		end else if (length_q > 8'(twwc_pkg::MAX_WINDOW)) begin
			eff_len = 8'(twwc_pkg::MAX_WINDOW);
		end else begin
			eff_len = length_q;
		end
		win_end = {1'b0, shift_q} + {1'b0, eff_len};
		fit_sum = {1'b0, pos_q} + 17'(eff_len) + 17'(shift_q);
		take    = (holdoff_q == '0)
		       && (sample_s1.trigger_sample > threshold_q)
		       && (fit_sum < {1'b0, line_len_q})
		       && (waves_q < max_waves_q)
		       && (cnt_q < CW'(CAPTURE_SLOTS));
		pos_inc = pos_q + 16'd1;
		wrap    = (pos_inc >= line_len_q) || (pos_inc == '0);
	end

	// divide by 16 toward zero
	assign laser_adj = {sample_s1.laser_sample[15], sample_s1.laser_sample}
	                 + (sample_s1.laser_sample[15] ? 17'd15 : 17'd0);
	assign hdr.line_number  = line_q;
	assign hdr.scaled_value = laser_adj[15:4];

	// window list with the new window appended, emission and freeing
	always_comb begin
		nfree = '0;
		for (int i = 0; i < CAPTURE_SLOTS; i++) begin
			if (take && cnt_q == CW'(i)) begin
				ea[i] = '0;
				ew[i] = waves_q;
			end else begin
				ea[i] = age_q[i];
				ew[i] = slot_wave_q[i];
			end
			live[i] = ((CW + 1)'(i) < ({1'b0, cnt_q} + (CW + 1)'(take)));
			emit[i] = live[i] && (ea[i] >= {1'b0, shift_q}) && (ea[i] < win_end);
			gone[i] = live[i] && ((10'(ea[i]) + 10'd1) >= {1'b0, win_end});
			eoff[i] = 7'(ea[i] - {1'b0, shift_q});
			nfree   = nfree + CW'(gone[i]);
		end
	end

	// age the list and drop the freed oldest entries
	always_comb begin
		for (int i = 0; i < CAPTURE_SLOTS; i++) begin
			age_nxt[i]  = '0;
			wave_nxt[i] = '0;
			for (int j = 0; j < CAPTURE_SLOTS; j++) begin
				if (j == i + int'(nfree)) begin
					age_nxt[i]  = ea[j] + 9'd1;
					wave_nxt[i] = ew[j];
				end
			end
		end
		cnt_new = {1'b0, cnt_q} + (CW + 1)'(take) - (CW + 1)'(nfree);
	end

	// state update, one input per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			line_q    <= '0;
			holdoff_q <= '0;
			waves_q   <= '0;
			cnt_q     <= '0;
		end else if (proc) begin
			cnt_q <= cnt_new[CW-1:0];
			if (wrap) begin
				pos_q     <= '0;
				line_q    <= line_q + 16'd1;
				waves_q   <= '0;
				holdoff_q <= '0;
			end else begin
				pos_q <= pos_inc;
				if (holdoff_q != '0) begin
					holdoff_q <= holdoff_q - 8'd1;
				end else if (take) begin
					holdoff_q <= holdoff_len_q;
				end
				if (take) begin
					waves_q <= waves_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			age_q       <= age_nxt;
			slot_wave_q <= wave_nxt;
		end
	end

	twwc_drain #(
		.CAPTURE_SLOTS(CAPTURE_SLOTS)
	) u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (proc),
		.mask         (emit),
		.wave         (ew),
		.offset       (eoff),
		.hdr          (hdr),
		.ready        (batch_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// window count never exceeds the slot count
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPTURE_SLOTS))
		else $error("window count above slot count");

	// at most one window opens per input
	assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> ({1'b0, cnt_q} <= {1'b0, $past(cnt_q)} + (CW + 1)'(1)))
		else $error("more than one window opened in one input");

	// a result that is not the last of its input is followed at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !result.last_of_item) |=> result_valid)
		else $error("results of one input interrupted");

endmodule
